// ----- rtl/lrev_pkg.sv -----
// Package for the left-to-right expression evaluator.
// Holds the symbol codes, the operator kinds, the FSM states and the
// command and status structs between controller and datapath. No dependencies.
package lrev_pkg;

  localparam int DATA_W = 32;
  localparam int SYM_W  = 8;
  localparam int CNT_W  = $clog2(DATA_W);

  localparam logic [SYM_W-1:0] SYM_TERM  = 8'h00;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_TIMES = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OPK_ADD,
    OPK_SUB,
    OPK_MUL,
    OPK_DIV,
    OPK_NOP
  } opk_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DIV,
    ST_DIV_FIX,
    ST_FINISH,
    ST_POST
  } state_t;

  typedef struct packed {
    logic lead;      // leading minus: set pending operator only
    logic digit;     // fold a digit into the operand
    logic capture;   // latch an operator or terminator beat
    logic apply;     // apply +, -, * or load the divider
    logic div_step;  // one restoring division step
    logic div_fix;   // sign correction, quotient into accumulator
    logic finish;    // install the new operator, clear the operand
    logic post;      // load the output register and clear the state
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_term;
    logic is_digit;
    logic lead_minus;
    logic digit_seen;
    logic term_pending;
    logic div_zero;
    logic div_last;
    opk_t op_kind;
  } dp_status_t;

endpackage

// ----- rtl/left_to_right_expression_evaluator.sv -----
// Top level of the left-to-right expression evaluator.
// Joins the controller (lrev_ctrl) and the datapath (lrev_dp); uses lrev_pkg.
//
//   Channel  Ports                          Beat carries
//   input    in_valid, in_ready, in_symbol  one ASCII symbol, zero ends the expression
//   output   out_valid, out_ready,          the signed 32-bit value of one expression
//            out_result_value
//
// A digit beat or a leading minus is taken in the idle state alone. An operator
// beat for +, - and * and for unknown operators passes accept, apply and finish;
// the division operator adds the bit-serial divider, which retires one quotient bit
// per cycle over 32 steps, and a sign fix before finish. A terminator adds a post
// step, plus the apply of the pending operator when a digit came since the last one.
// Reset is synchronous and active low; it empties the output register and returns
// the evaluator to the start of an expression. The result sits in an output
// register, so symbols keep flowing while it waits; only a second finished
// result stalls the input until the first one is taken.
module left_to_right_expression_evaluator
  import lrev_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SYM_W-1:0]         in_symbol,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_result_value
);

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [DATA_W-1:0] result_bits;

  // The controller owns the handshakes and sequences every multi-cycle step.
  lrev_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the expression state, the arithmetic and the result.
  lrev_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_symbol        (in_symbol),
    .cmd              (cmd),
    .status           (status),
    .out_result_value (result_bits)
  );

  assign out_result_value = signed'(result_bits);

endmodule

// ----- rtl/lrev_ctrl.sv -----
// Controller state machine of the expression evaluator.
// Sequences symbol beats, operator application, division and result posting.
// Depends on lrev_pkg.
module lrev_ctrl
  import lrev_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.is_term) begin
            cmd.capture = 1'b1;
            state_nxt   = status.digit_seen ? ST_APPLY : ST_POST;
          end else if (status.lead_minus) begin
            cmd.lead = 1'b1;
          end else if (status.is_digit) begin
            cmd.digit = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (status.op_kind == OPK_DIV && !status.div_zero) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_DIV_FIX;
        end
      end
      ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.term_pending) begin
          state_nxt = ST_POST;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_POST: begin
        if (!out_valid_r || out_ready) begin
          cmd.post      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/lrev_dp.sv -----
// Datapath of the expression evaluator: accumulator, operand, pending
// operator, one multiplier, a bit-serial restoring divider and the output register.
// Depends on lrev_pkg.
module lrev_dp
  import lrev_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SYM_W-1:0]  in_symbol,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  output logic [DATA_W-1:0] out_result_value
);

  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] opnd_r, opnd_nxt;
  logic [SYM_W-1:0]  op_r, op_nxt;
  logic [SYM_W-1:0]  new_op_r, new_op_nxt;
  logic              start_r, start_nxt;
  logic              dig_r, dig_nxt;
  logic              term_r, term_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;

  opk_t              op_kind;
  logic [DATA_W-1:0] product;
  logic [DATA_W-1:0] opnd_x10;
  logic [3:0]        digit_val;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              acc_neg;
  logic              opnd_neg;

  always_comb begin
    unique case (op_r)
      SYM_PLUS:  op_kind = OPK_ADD;
      SYM_MINUS: op_kind = OPK_SUB;
      SYM_TIMES: op_kind = OPK_MUL;
      SYM_DIV:   op_kind = OPK_DIV;
      default:   op_kind = OPK_NOP;
    endcase
  end

  assign status.is_term      = (in_symbol == SYM_TERM);
  assign status.is_digit     = (in_symbol >= SYM_ZERO) && (in_symbol <= SYM_NINE);
  assign status.lead_minus   = start_r && (in_symbol == SYM_MINUS);
  assign status.digit_seen   = dig_r;
  assign status.term_pending = term_r;
  assign status.div_zero     = (opnd_r == '0);
  assign status.div_last     = (cnt_r == CNT_W'(DATA_W - 1));
  assign status.op_kind      = op_kind;

  assign digit_val = 4'(in_symbol - SYM_ZERO);
  assign opnd_x10  = {opnd_r[DATA_W-4:0], 3'b000} + {opnd_r[DATA_W-2:0], 1'b0};
  assign product   = acc_r * opnd_r;
  assign acc_neg   = acc_r[DATA_W-1];
  assign opnd_neg  = opnd_r[DATA_W-1];
  assign shifted   = {rem_r, quo_r[DATA_W-1]};
  assign diff      = shifted - {1'b0, dvs_r};

  always_comb begin
    acc_nxt    = acc_r;
    opnd_nxt   = opnd_r;
    op_nxt     = op_r;
    new_op_nxt = new_op_r;
    start_nxt  = start_r;
    dig_nxt    = dig_r;
    term_nxt   = term_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    res_nxt    = res_r;

    if (cmd.lead) begin
      op_nxt    = SYM_MINUS;
      start_nxt = 1'b0;
    end
    if (cmd.digit) begin
      opnd_nxt  = opnd_x10 + DATA_W'(digit_val);
      dig_nxt   = 1'b1;
      start_nxt = 1'b0;
    end
    if (cmd.capture) begin
      new_op_nxt = in_symbol;
      term_nxt   = status.is_term;
      start_nxt  = 1'b0;
    end
    if (cmd.apply) begin
      case (op_kind)
        OPK_ADD: acc_nxt = acc_r + opnd_r;
        OPK_SUB: acc_nxt = acc_r - opnd_r;
        OPK_MUL: acc_nxt = product;
        OPK_DIV: begin
          rem_nxt = '0;
          quo_nxt = acc_neg ? -acc_r : acc_r;
          dvs_nxt = opnd_neg ? -opnd_r : opnd_r;
          neg_nxt = acc_neg ^ opnd_neg;
          cnt_nxt = '0;
        end
        default: acc_nxt = acc_r;
      endcase
    end
    if (cmd.div_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
    end
    if (cmd.div_fix) begin
      acc_nxt = neg_r ? -quo_r : quo_r;
    end
    if (cmd.finish) begin
      op_nxt   = new_op_r;
      opnd_nxt = '0;
      dig_nxt  = 1'b0;
    end
    if (cmd.post) begin
      res_nxt   = acc_r;
      acc_nxt   = '0;
      opnd_nxt  = '0;
      op_nxt    = SYM_PLUS;
      start_nxt = 1'b1;
      dig_nxt   = 1'b0;
      term_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      opnd_r  <= '0;
      op_r    <= SYM_PLUS;
      start_r <= 1'b1;
      dig_r   <= 1'b0;
      term_r  <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      opnd_r  <= opnd_nxt;
      op_r    <= op_nxt;
      start_r <= start_nxt;
      dig_r   <= dig_nxt;
      term_r  <= term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_op_r <= new_op_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dvs_r    <= dvs_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    res_r    <= res_nxt;
  end

  assign out_result_value = res_r;

endmodule

// ----- rtl/lrev_checker.sv -----
// Port-level checker for the expression evaluator, bound to the top level.
// Tracks terminator beats against result beats; uses lrev_pkg.
module lrev_checker
  import lrev_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [SYM_W-1:0]         in_symbol,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_result_value
);

  logic [1:0] pend_r, pend_nxt;
  logic       term_beat;
  logic       out_beat;

  assign term_beat = in_valid && in_ready && (in_symbol == SYM_TERM);
  assign out_beat  = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (term_beat && !out_beat) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_beat && !term_beat) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("result changed or dropped while stalled");

  // A result is only shown for a terminator that has been taken.
  a_out_has_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat without a terminator");

  // At most one result waits while a second one is being finished.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 2'd2)
    else $error("too many expressions outstanding");

  // With two expressions outstanding the input must be stalled.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 |-> !in_ready)
    else $error("input taken while two results are outstanding");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind left_to_right_expression_evaluator lrev_checker u_lrev_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for left_to_right_expression_evaluator.
// A scoreboard class predicts each expression value from the accepted symbols;
// plain tasks drive the input and drain the output. Depends on lrev_pkg and the RTL.

class expr_scoreboard;
  localparam logic [31:0] RADIX = 32'd10;

  // Predicted evaluator state.
  logic [31:0] accum;
  logic [31:0] operand;
  logic [7:0]  pending_op;
  bit          at_start;
  bit          digit_seen;

  logic signed [31:0] expected_values[$];
  int unsigned        errors;

  function new();
    errors = 0;
    clear_state();
  endfunction

  function void clear_state();
    accum      = '0;
    operand    = '0;
    pending_op = lrev_pkg::SYM_PLUS;
    at_start   = 1'b1;
    digit_seen = 1'b0;
  endfunction

  // Signed division on raw bits, truncating toward zero and wrapping.
  function logic [31:0] quotient(logic [31:0] num, logic [31:0] den);
    logic [31:0] mag_num;
    logic [31:0] mag_den;
    logic [31:0] q;
    mag_num = num[31] ? -num : num;
    mag_den = den[31] ? -den : den;
    q = mag_num / mag_den;
    if (num[31] ^ den[31]) begin
      q = -q;
    end
    return q;
  endfunction

  function void apply_pending_op();
    case (pending_op)
      lrev_pkg::SYM_PLUS:  accum = accum + operand;
      lrev_pkg::SYM_MINUS: accum = accum - operand;
      lrev_pkg::SYM_TIMES: accum = accum * operand;
      lrev_pkg::SYM_DIV: begin
        if (operand != 0) begin
          accum = quotient(accum, operand);
        end
      end
      default: ;
    endcase
  endfunction

  // Called once per accepted input beat.
  function void note_symbol(logic [7:0] sym);
    if (sym == lrev_pkg::SYM_TERM) begin
      if (digit_seen) begin
        apply_pending_op();
      end
      expected_values.push_back(accum);
      clear_state();
      return;
    end
    if (at_start && sym == lrev_pkg::SYM_MINUS) begin
      pending_op = lrev_pkg::SYM_MINUS;
      at_start   = 1'b0;
      return;
    end
    at_start = 1'b0;
    if (sym >= lrev_pkg::SYM_ZERO && sym <= lrev_pkg::SYM_NINE) begin
      operand    = operand * RADIX + {24'd0, sym - lrev_pkg::SYM_ZERO};
      digit_seen = 1'b1;
      return;
    end
    apply_pending_op();
    pending_op = sym;
    operand    = '0;
    digit_seen = 1'b0;
  endfunction

  // Called once per accepted output beat.
  function void check_result(logic signed [31:0] actual);
    logic signed [31:0] expected;
    if (expected_values.size() == 0) begin
      $error("result_value beat with no expression pending: actual %0d", actual);
      errors++;
      return;
    end
    expected = expected_values.pop_front();
    if (actual !== expected) begin
      $error("result_value mismatch: expected %0d, actual %0d", expected, actual);
      errors++;
    end
  endfunction

  function int pending_count();
    return expected_values.size();
  endfunction
endclass

module testbench;
  import lrev_pkg::*;

  localparam int TARGET_SYMBOLS = 1500;
  // Longest beat is a division; this covers a terminator
  // that applies one, plus slack for the output register.
  localparam int SETTLE_CYCLES  = 80;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [SYM_W-1:0]         in_symbol = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_result_value;

  expr_scoreboard scoreboard = new();

  // Symbols of the expression that is about to be sent.
  logic [SYM_W-1:0] expr_text[$];
  int               symbols_sent = 0;

  // When a side is steady it never idles; otherwise it draws a gap per beat.
  bit sender_steady = 1'b0;
  bit sink_steady   = 1'b0;

  always #5 clk = ~clk;

  left_to_right_expression_evaluator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_symbol        (in_symbol),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value)
  );

  function automatic int draw_gap(bit steady);
    if (steady) begin
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      expr_text.push_back(s[i]);
    end
  endfunction

  // Decimal digits of a value; anything above 32 bits wraps inside the block.
  function automatic void add_number(longint unsigned value);
    add_text($sformatf("%0d", value));
  endfunction

  // An operand is mostly small, sometimes a full 32-bit or longer number,
  // sometimes absent so that an empty operand counts as zero.
  function automatic void add_operand();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      return;
    end else if (pick < 10) begin
      add_number($urandom_range(0, 99));
    end else if (pick < 14) begin
      add_number($urandom_range(0, 99999));
    end else if (pick < 17) begin
      add_number($urandom);
    end else if (pick == 17) begin
      add_number(64'd2147483648);
    end else if (pick == 18) begin
      add_number(64'd4294967295);
    end else begin
      add_number({$urandom, $urandom});
    end
  endfunction

  // Mostly the four real operators; the rest are arbitrary nonzero non-digit bytes
  // that the block takes as operators, which leave the accumulator alone unless they hit one of the four.
  function automatic void add_operator();
    int               pick;
    logic [SYM_W-1:0] sym;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: expr_text.push_back(SYM_PLUS);
      2, 3: expr_text.push_back(SYM_MINUS);
      4, 5: expr_text.push_back(SYM_TIMES);
      6, 7: expr_text.push_back(SYM_DIV);
      default: begin
        do begin
          sym = SYM_W'($urandom_range(1, 255));
        end while (sym >= SYM_ZERO && sym <= SYM_NINE);
        expr_text.push_back(sym);
      end
    endcase
  endfunction

  // Offer one input beat and hold it until the evaluator takes it. Valid is
  // only lowered when a gap follows, so back-to-back beats keep it high.
  task automatic send_symbol(input logic [SYM_W-1:0] sym);
    int gap;
    gap = draw_gap(sender_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    do @(posedge clk); while (!in_ready);
    scoreboard.note_symbol(sym);
    symbols_sent++;
  endtask

  task automatic flush_text();
    while (expr_text.size() != 0) begin
      send_symbol(expr_text.pop_front());
    end
  endtask

  // Hold the input off until every predicted value has been seen. Valid is
  // dropped first so the beat that was just taken is not offered again.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (scoreboard.pending_count() != 0);
  endtask

  // One random expression, terminator included. Most are well formed with
  // random content; a few are byte noise and a few hit the wrapping quotient.
  task automatic send_random_expression();
    int kind;
    int terms;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) expr_text.push_back(SYM_W'($urandom_range(1, 255)));
    end else if (kind == 1) begin
      add_text("-2147483648/4294967295");
      if ($urandom_range(0, 1) == 1) begin
        add_operator();
        add_operand();
      end
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        expr_text.push_back(SYM_MINUS);
      end
      terms = $urandom_range(1, 6);
      for (int t = 0; t < terms; t++) begin
        add_operand();
        // A trailing operator is left in now and then.
        if (t < terms - 1 || $urandom_range(0, 7) == 0) begin
          add_operator();
        end
      end
    end
    expr_text.push_back(SYM_TERM);
    flush_text();
  endtask

  // Output side: draw a stall for every beat, then take the next result.
  initial begin
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = draw_gap(sink_steady);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      scoreboard.check_result(out_result_value);
    end
  end

  // Stimulus and verdict.
  initial begin
    int expr_count;
    expr_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A leading minus followed by a truncating division.
    add_text("-9/2");
    expr_text.push_back(SYM_TERM);
    flush_text();
    // All-ones byte as the first symbol acts as an unknown operator; then
    // addition, a division by zero that is skipped, a multiplication, and a
    // trailing operator that the terminator does not apply.
    expr_text.push_back(8'hFF);
    add_text("3+4/0*5-");
    expr_text.push_back(SYM_TERM);
    flush_text();
    // An empty expression.
    send_symbol(SYM_TERM);
    // An operand long enough to wrap past 32 bits.
    add_text("99999999999");
    expr_text.push_back(SYM_TERM);
    flush_text();

    // The sender waits here for every expected result before going on.
    drain_results();

    // Random part. The idling style of both sides changes every few
    // expressions, so some stretches run with no gaps at all.
    while (symbols_sent < TARGET_SYMBOLS) begin
      if (expr_count % 6 == 0) begin
        sender_steady = ($urandom_range(0, 3) == 0);
        sink_steady   = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 24) == 0) begin
        drain_results();
      end
      send_random_expression();
      expr_count++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (scoreboard.errors == 0 && scoreboard.pending_count() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, where every beat is a
  // division and both sides idle for their longest gap.
  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
